@@ hdl/iira_pkg.sv @@
// Shared types and constants for the indexed insert/remove array.
// Depends on nothing; every other file imports it.
`default_nettype none

package iira_pkg;

  localparam int OP_W           = 3;
  localparam int IDX_W          = 7;
  localparam int VAL_W          = 32;
  localparam int ERR_W          = 2;
  localparam int CNT_OUT_W      = 7;
  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_APPEND = 3'd1,
    OP_POP    = 3'd2,
    OP_INSERT = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_INDEX = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_FULL  = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    RA_IDX,
    RA_LAST,
    RA_PTR_DN,
    RA_PTR_UP
  } raddr_sel_t;

  typedef enum logic [1:0] {
    WA_CNT,
    WA_IDX,
    WA_PTR_DN,
    WA_PTR_UP
  } waddr_sel_t;

  typedef struct packed {
    logic       latch_req;
    logic       cap_err;
    logic       rd_en;
    raddr_sel_t rd_sel;
    logic       wr_en;
    waddr_sel_t wr_sel;
    logic       wr_from_mem;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cap_result;
    logic       clr_result;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    err_t err;
    logic idx_eq_cnt;
    logic ptr_eq_idx;
    logic ptr_inc_lt_cnt;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/iira_intf.sv @@
// Request and result channel interfaces (valid/ready with payload).
// Depends on iira_pkg for field widths.
`default_nettype none

interface iira_in_if
  import iira_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output op, output index, output value, input ready);
  modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface iira_out_if
  import iira_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;
  logic [ERR_W-1:0]        error;
  logic [CNT_OUT_W-1:0]    count;

  modport source (output valid, output result_value, output error, output count, input ready);
  modport sink   (input valid, input result_value, input error, input count, output ready);
endinterface

`default_nettype wire

@@ hdl/iira_datapath.sv @@
// Element memory, count, request and result registers of the array.
// Depends on iira_pkg; driven by iira_ctrl through cmd_t, reports via sts_t.
`default_nettype none

module iira_datapath
  import iira_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cmd_t                    cmd,
  output sts_t                         sts,
  input  wire logic [OP_W-1:0]         in_op,
  input  wire logic [IDX_W-1:0]        in_index,
  input  wire logic signed [VAL_W-1:0] in_value,
  output logic signed [VAL_W-1:0]      out_result_value,
  output logic [ERR_W-1:0]             out_error,
  output logic [CNT_OUT_W-1:0]         out_count
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic [OP_W-1:0]         op_r;
  logic [IDX_W-1:0]        idx_r;
  logic [DATA_WIDTH-1:0]   val_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        ptr_r;
  logic signed [VAL_W-1:0] res_r;
  err_t                    err_r;

  logic [CW-1:0]    idx_ext, cnt_ext;
  logic [CNT_W-1:0] raddr, waddr;
  logic [DATA_WIDTH-1:0] wdata;
  err_t             err_c;

  assign idx_ext = CW'(idx_r);
  assign cnt_ext = CW'(count_r);

  always_comb begin
    err_c = ERR_OK;
    case (op_t'(op_r))
      OP_READ, OP_REMOVE: begin
        if (idx_ext >= cnt_ext) err_c = ERR_INDEX;
      end
      OP_APPEND: begin
        if (cnt_ext >= CW'(CAPACITY)) err_c = ERR_FULL;
      end
      OP_POP: begin
        if (count_r == '0) err_c = ERR_EMPTY;
      end
      OP_INSERT: begin
        if (idx_ext > cnt_ext) err_c = ERR_INDEX;
        else if (cnt_ext >= CW'(CAPACITY)) err_c = ERR_FULL;
      end
      default: err_c = ERR_OK;
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      RA_IDX:    raddr = CNT_W'(idx_ext);
      RA_LAST:   raddr = count_r - CNT_W'(1);
      RA_PTR_DN: raddr = ptr_r - CNT_W'(1);
      RA_PTR_UP: raddr = ptr_r + CNT_W'(1);
      default:   raddr = ptr_r;
    endcase
    case (cmd.wr_sel)
      WA_CNT:    waddr = count_r;
      WA_IDX:    waddr = CNT_W'(idx_ext);
      WA_PTR_DN: waddr = ptr_r - CNT_W'(1);
      WA_PTR_UP: waddr = ptr_r + CNT_W'(1);
      default:   waddr = count_r;
    endcase
    wdata = cmd.wr_from_mem ? rd_data_r : val_r;
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc)      count_nxt = count_r + CNT_W'(1);
    else if (cmd.cnt_dec) count_nxt = count_r - CNT_W'(1);
  end

  assign sts.op             = op_t'(op_r);
  assign sts.err            = err_c;
  assign sts.idx_eq_cnt     = (idx_ext == cnt_ext);
  assign sts.ptr_eq_idx     = (CW'(ptr_r) == idx_ext);
  assign sts.ptr_inc_lt_cnt = (({1'b0, ptr_r} + (CNT_W+1)'(1)) < {1'b0, count_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[waddr[AW-1:0]] <= wdata;
    if (cmd.rd_en) rd_data_r <= mem[raddr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      op_r  <= in_op;
      idx_r <= in_index;
      val_r <= DATA_WIDTH'(in_value);
    end
    if (cmd.rd_en) ptr_r <= raddr;
    if (cmd.cap_err) err_r <= err_c;
    if (cmd.cap_result) res_r <= VAL_W'(signed'(rd_data_r));
    else if (cmd.clr_result) res_r <= '0;
    if (cmd.load_out) begin
      out_result_value <= res_r;
      out_error        <= err_r;
      out_count        <= CNT_OUT_W'(cnt_ext);
    end
  end

endmodule

`default_nettype wire

@@ hdl/iira_ctrl.sv @@
// Sequencer of the array: steps one request through memory reads, shifts and writes.
// Depends on iira_pkg; drives iira_datapath through cmd_t.
`default_nettype none

module iira_ctrl
  import iira_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDCAP,
    S_SHUP,
    S_PUT,
    S_SHDN,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.cap_err = 1'b1;
        if (sts.err != ERR_OK) begin
          cmd.clr_result = 1'b1;
          state_nxt      = S_FIN;
        end else begin
          case (sts.op)
            OP_READ, OP_REMOVE: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_IDX;
              state_nxt  = S_RDCAP;
            end
            OP_POP: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_LAST;
              state_nxt  = S_RDCAP;
            end
            OP_APPEND: begin
              cmd.wr_en      = 1'b1;
              cmd.wr_sel     = WA_CNT;
              cmd.cnt_inc    = 1'b1;
              cmd.clr_result = 1'b1;
              state_nxt      = S_FIN;
            end
            OP_INSERT: begin
              cmd.clr_result = 1'b1;
              if (sts.idx_eq_cnt) begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WA_CNT;
                cmd.cnt_inc = 1'b1;
                state_nxt   = S_FIN;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RA_LAST;
                state_nxt  = S_SHUP;
              end
            end
            default: begin
              cmd.clr_result = 1'b1;
              state_nxt      = S_FIN;
            end
          endcase
        end
      end
      S_RDCAP: begin
        cmd.cap_result = 1'b1;
        if (sts.op == OP_READ) begin
          state_nxt = S_FIN;
        end else if (sts.ptr_inc_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_PTR_UP;
          state_nxt  = S_SHDN;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_SHDN: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_sel      = WA_PTR_DN;
        cmd.wr_from_mem = 1'b1;
        if (sts.ptr_inc_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_PTR_UP;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_SHUP: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_sel      = WA_PTR_UP;
        cmd.wr_from_mem = 1'b1;
        if (sts.ptr_eq_idx) begin
          state_nxt = S_PUT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_PTR_DN;
        end
      end
      S_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WA_IDX;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)                  out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/indexed_insert_remove_array.sv @@
// Indexed insert/remove array: fixed-capacity ordered store of signed words.
// Insert at index i below the count n moves n - i entries up, and remove at index i moves
// n - 1 - i entries down: one entry moves per cycle (one read, one write).
// One request in flight; the next is taken once the result is in the output register.
// Synchronous active-low reset empties the store (count zero); memory contents are kept.
`default_nettype none

module indexed_insert_remove_array
  import iira_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  iira_in_if.sink    in_ch,
  iira_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  iira_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iira_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_ch.op),
    .in_index         (in_ch.index),
    .in_value         (in_ch.value),
    .out_result_value (out_ch.result_value),
    .out_error        (out_ch.error),
    .out_count        (out_ch.count)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.error == ERR_FULL) |-> out_ch.count == CNT_OUT_W'(CAPACITY))
    else $error("full flagged below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.error == ERR_EMPTY) |-> out_ch.count == '0)
    else $error("empty flagged with elements held");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.error != ERR_OK) |-> out_ch.result_value == '0)
    else $error("nonzero word on error");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for indexed_insert_remove_array: random and directed requests with
// a running copy of the store that predicts every result word.
// Depends on iira_pkg, the channel interfaces and the block itself.
`default_nettype none

module tb_top
  import iira_pkg::*;
();

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int AW           = $clog2(CAPACITY);
  localparam int OP_CODES     = 2 ** OP_W;
  localparam int IDX_MAX      = 2 ** IDX_W - 1;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    err_t                    error;
    logic [CNT_OUT_W-1:0]    count;
  } outcome_t;

  logic clk;
  logic rst_n;
  logic calm;
  int   failures;
  int   cycle_count;

  logic signed [VAL_W-1:0] held_words [CAPACITY];
  int unsigned             held_count;
  outcome_t                awaited[$];
  outcome_t                due;

  iira_in_if  in_ch ();
  iira_out_if out_ch ();

  indexed_insert_remove_array i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic outcome_t apply_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                             logic signed [VAL_W-1:0] val);
    outcome_t res;
    res.value = '0;
    res.error = ERR_OK;
    case (op)
      OP_READ: begin
        if (idx >= held_count) res.error = ERR_INDEX;
        else res.value = held_words[AW'(idx)];
      end
      OP_APPEND: begin
        if (held_count >= CAPACITY) begin
          res.error = ERR_FULL;
        end else begin
          held_words[AW'(held_count)] = val;
          held_count++;
        end
      end
      OP_POP: begin
        if (held_count == 0) begin
          res.error = ERR_EMPTY;
        end else begin
          held_count--;
          res.value = held_words[AW'(held_count)];
        end
      end
      OP_INSERT: begin
        if (idx > held_count) begin
          res.error = ERR_INDEX;
        end else if (held_count >= CAPACITY) begin
          res.error = ERR_FULL;
        end else begin
          for (int i = held_count; i > idx; i--) held_words[AW'(i)] = held_words[AW'(i-1)];
          held_words[AW'(idx)] = val;
          held_count++;
        end
      end
      OP_REMOVE: begin
        if (idx >= held_count) begin
          res.error = ERR_INDEX;
        end else begin
          res.value = held_words[AW'(idx)];
          for (int i = idx; i + 1 < held_count; i++) held_words[AW'(i)] = held_words[AW'(i+1)];
          held_count--;
        end
      end
      default: ;
    endcase
    res.count = held_count[CNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic send_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                           logic signed [VAL_W-1:0] val);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.index <= idx;
    in_ch.value <= val;
    do @(posedge clk); while (!in_ch.ready);
    awaited.push_back(apply_request(op, idx, val));
  endtask

  task automatic report(string field, longint want, longint got);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    failures++;
  endtask

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 9);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual value %0d error %0d count %0d",
                 $time, out_ch.result_value, out_ch.error, out_ch.count);
        failures++;
      end else begin
        due = awaited.pop_front();
        if (out_ch.result_value !== due.value) report("value", due.value, out_ch.result_value);
        if (out_ch.error !== due.error) report("error", due.error, out_ch.error);
        if (out_ch.count !== due.count) report("count", due.count, out_ch.count);
      end
    end
  end

  task automatic test_empty_store();
    send_word(OP_READ, '0, 32'sd5);
    send_word(OP_REMOVE, '0, 32'sd0);
    send_word(OP_POP, '0, 32'sd0);
    send_word(OP_INSERT, 7'd1, 32'sd9);
    send_word(OP_READ, IDX_W'(IDX_MAX), 32'sd0);
    for (int c = OP_REMOVE + 1; c < OP_CODES; c++)
      send_word(OP_W'(c), IDX_W'(IDX_MAX), -32'sd1);
  endtask

  task automatic test_edge_values();
    send_word(OP_INSERT, '0, 32'sh7fff_ffff);
    send_word(OP_APPEND, IDX_W'(IDX_MAX), 32'sh8000_0000);
    send_word(OP_INSERT, 7'd1, 32'sd0);
    send_word(OP_APPEND, '0, -32'sd1);
    send_word(OP_INSERT, 7'd4, 32'sd1);
    send_word(OP_READ, 7'd0, 32'sd0);
    send_word(OP_READ, 7'd4, 32'sd0);
    send_word(OP_READ, 7'd5, 32'sd0);
    send_word(OP_REMOVE, 7'd1, 32'sd0);
    send_word(OP_REMOVE, 7'd3, 32'sd0);
    send_word(OP_POP, '0, 32'sd0);
    send_word(OP_INSERT, 7'd5, 32'sd3);
    send_word(OP_REMOVE, 7'd2, 32'sd0);
  endtask

  task automatic test_full_store();
    while (held_count < CAPACITY) begin
      if ($urandom_range(0, 1))
        send_word(OP_APPEND, IDX_W'($urandom_range(0, IDX_MAX)), $urandom);
      else send_word(OP_INSERT, IDX_W'($urandom_range(0, held_count)), $urandom);
    end
    send_word(OP_APPEND, '0, $urandom);
    send_word(OP_INSERT, 7'd10, $urandom);
    send_word(OP_INSERT, IDX_W'(CAPACITY), $urandom);
    send_word(OP_INSERT, IDX_W'(CAPACITY + 1), $urandom);
    send_word(OP_INSERT, IDX_W'(IDX_MAX), $urandom);
    send_word(OP_READ, IDX_W'(CAPACITY - 1), $urandom);
    send_word(OP_READ, IDX_W'(CAPACITY), $urandom);
    send_word(OP_REMOVE, IDX_W'(CAPACITY - 1), $urandom);
    send_word(OP_INSERT, '0, $urandom);
    send_word(OP_REMOVE, '0, $urandom);
    while (held_count > 0) begin
      if ($urandom_range(0, 1))
        send_word(OP_POP, IDX_W'($urandom_range(0, IDX_MAX)), $urandom);
      else send_word(OP_REMOVE, IDX_W'($urandom_range(0, held_count - 1)), $urandom);
    end
    send_word(OP_POP, '0, $urandom);
  endtask

  task automatic test_random_traffic(int unsigned items);
    bit               filling;
    int unsigned      pick;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    filling = 1'b1;
    for (int unsigned n = 0; n < items; n++) begin
      calm <= (n >= items / 3) && (n < items / 2);
      if (held_count == 0) filling = 1'b1;
      else if (held_count == CAPACITY && $urandom_range(0, 7) == 0) filling = 1'b0;
      pick = $urandom_range(0, 99);
      if (filling) begin
        if (pick < 30) op = OP_APPEND;
        else if (pick < 55) op = OP_INSERT;
        else if (pick < 70) op = OP_READ;
        else if (pick < 80) op = OP_POP;
        else if (pick < 96) op = OP_REMOVE;
        else op = OP_W'($urandom_range(OP_REMOVE + 1, OP_CODES - 1));
      end else begin
        if (pick < 10) op = OP_APPEND;
        else if (pick < 20) op = OP_INSERT;
        else if (pick < 35) op = OP_READ;
        else if (pick < 65) op = OP_POP;
        else if (pick < 96) op = OP_REMOVE;
        else op = OP_W'($urandom_range(OP_REMOVE + 1, OP_CODES - 1));
      end
      if ($urandom_range(0, 9) == 0 || !(op inside {OP_READ, OP_INSERT, OP_REMOVE}))
        idx = IDX_W'($urandom_range(0, IDX_MAX));
      else if (op == OP_INSERT) idx = IDX_W'($urandom_range(0, held_count));
      else idx = IDX_W'($urandom_range(0, (held_count > 0) ? held_count - 1 : 0));
      send_word(op, idx, $urandom);
    end
    calm <= 1'b0;
  endtask

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    failures     = 0;
    held_count   = 0;
    calm         <= 1'b0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.op     <= '0;
    in_ch.index  <= '0;
    in_ch.value  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_store();
    test_edge_values();
    test_full_store();
    test_random_traffic(2000);

    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
